/* src/cel_pkg.sv */
// Package with shared types, constants and the log table of the cross-entropy loss unit.
package cel_pkg;

    localparam int LOG_TABLE_DEPTH = 256;
    localparam int IDX_W = $clog2(LOG_TABLE_DEPTH);
    localparam int TAB_W = 16;
    localparam int LN2_Q16 = 45426;
    localparam real INV_DEPTH = 1.0 / real'(LOG_TABLE_DEPTH);

    localparam int P_W = 17;
    localparam int SUM_W = 48;
    localparam int LN_W = 21;
    localparam int TERM_W = 22;
    localparam int DVD_W = 49;
    localparam int DSR_W = 30;
    localparam int RMD_W = DSR_W + 1;
    localparam int CNT_W = $clog2(DVD_W);
    localparam int DIV_STEPS = DVD_W;

    localparam int ADDR_W = 4;
    localparam logic [ADDR_W-1:0] ADDR_FLOOR = 4'h0;
    localparam logic [ADDR_W-1:0] ADDR_BATCH = 4'h4;
    localparam logic [ADDR_W-1:0] ADDR_GRAD = 4'h8;

    localparam logic ACT_FORWARD = 1'b0;
    localparam logic ACT_BACKWARD = 1'b1;

    typedef enum logic [3:0] {
        S_IDLE,
        S_LOG,
        S_TAB,
        S_INTP,
        S_LNSUM,
        S_TERM,
        S_ACC,
        S_LDF,
        S_BMUL,
        S_DIV,
        S_FIN
    } state_t;

    typedef struct packed {
        logic capture;
        logic log_norm;
        logic tab_read;
        logic interp;
        logic ln_sum;
        logic term;
        logic acc;
        logic load_fwd;
        logic load_bwd;
        logic div_step;
        logic finish;
    } cmd_t;

    typedef struct packed {
        logic act;
        logic last;
    } status_t;

    typedef logic [TAB_W-1:0] ln_tab_t [0:LOG_TABLE_DEPTH];

    function automatic ln_tab_t build_ln_tab();
        ln_tab_t t;
        real x;
        for (int k = 0; k <= LOG_TABLE_DEPTH; k++)
        begin
            x = $ln(1.0 + real'(k) * INV_DEPTH) * 65536.0;
            t[k] = TAB_W'($rtoi(x + 0.5));
        end
        return t;
    endfunction

    localparam ln_tab_t LN_TAB = build_ln_tab();

endpackage

/* src/cel_ctrl.sv */
// Controller state machine that sequences the log, accumulate and divide steps.
module cel_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    output logic              out_valid,
    input  logic              out_stall,
    input  cel_pkg::status_t  sts,
    output cel_pkg::cmd_t     cmd
);
    import cel_pkg::*;

    state_t state_reg, state_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic out_valid_reg, out_valid_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            cnt_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cnt_next = cnt_reg;
        out_valid_next = out_valid_reg && out_stall;
        cmd = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next = S_LOG;
                end
            end
            S_LOG:
            begin
                if (sts.act == ACT_BACKWARD)
                begin
                    cmd.load_bwd = 1'b1;
                    cnt_next = '0;
                    state_next = S_DIV;
                end
                else
                begin
                    cmd.log_norm = 1'b1;
                    state_next = S_TAB;
                end
            end
            S_TAB:
            begin
                cmd.tab_read = 1'b1;
                state_next = S_INTP;
            end
            S_INTP:
            begin
                cmd.interp = 1'b1;
                state_next = S_LNSUM;
            end
            S_LNSUM:
            begin
                cmd.ln_sum = 1'b1;
                state_next = S_TERM;
            end
            S_TERM:
            begin
                cmd.term = 1'b1;
                state_next = S_ACC;
            end
            S_ACC:
            begin
                cmd.acc = 1'b1;
                state_next = sts.last ? S_LDF : S_IDLE;
            end
            S_LDF:
            begin
                cmd.load_fwd = 1'b1;
                cnt_next = '0;
                state_next = S_DIV;
            end
            S_BMUL:
            begin
                cmd.load_bwd = 1'b1;
                cnt_next = '0;
                state_next = S_DIV;
            end
            S_DIV:
            begin
                cmd.div_step = 1'b1;
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(DIV_STEPS - 1))
                begin
                    state_next = S_FIN;
                end
            end
            S_FIN:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    cmd.finish = 1'b1;
                    out_valid_next = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign in_stall = (state_reg != S_IDLE);
    assign out_valid = out_valid_reg;

`ifndef SYNTHESIS
    a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> (state_reg == S_LOG))
        else $error("accepted request did not start processing");
    a_div_ends: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DIV && cnt_reg == CNT_W'(DIV_STEPS - 1)) |=> (state_reg == S_FIN))
        else $error("division did not finish after its step count");
    a_out_from_fin: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> ($past(state_reg) == S_FIN))
        else $error("result appeared without a finish step");
`endif

endmodule

/* src/cel_datapath.sv */
// Datapath with the log interpolation, loss accumulator and shared bit-serial divider.
module cel_datapath (
    input  logic                          clk,
    input  logic                          rst_n,
    input  cel_pkg::cmd_t                 cmd,
    output cel_pkg::status_t              sts,
    input  logic                          action,
    input  logic [16:0]                   prob,
    input  logic [16:0]                   label,
    input  logic                          last,
    input  logic [15:0]                   prob_floor,
    input  logic [12:0]                   batch_size,
    input  logic signed [31:0]            upstream_grad,
    output logic                          kind,
    output logic signed [31:0]            value
);
    import cel_pkg::*;

    logic act_reg, last_reg;
    logic [P_W-1:0] p_reg, label_reg;
    logic [4:0] nexp_reg;
    logic [IDX_W-1:0] idx_reg;
    logic [15:0] rem_reg;
    logic [TAB_W-1:0] lo_reg, diff_reg;
    logic [15:0] intp_reg;
    logic signed [LN_W-1:0] ln_reg;
    logic signed [TERM_W-1:0] term_reg;
    logic signed [SUM_W-1:0] sum_reg, sum_next;
    logic [DVD_W-1:0] dvd_reg;
    logic [DSR_W-1:0] dsr_reg;
    logic [RMD_W-1:0] rmd_reg;
    logic neg_reg;
    logic kind_reg;
    logic signed [31:0] value_reg;

    logic [15:0] floor_eff;
    logic [12:0] batch_eff;
    logic [P_W-1:0] p_eff;
    logic [4:0] msb;
    logic [P_W-1:0] norm;
    logic [31:0] interp_prod;
    logic [16:0] lm;
    logic [19:0] ln2_part;
    logic [19:0] ln_mag;
    logic [36:0] term_prod;
    logic [20:0] tmag;
    logic signed [SUM_W:0] acc_wide;
    logic [SUM_W-1:0] sum_mag;
    logic [31:0] gmag;
    logic [RMD_W-1:0] rmd_sh;
    logic qbit;
    logic neg_out;
    logic signed [31:0] result;

    assign floor_eff = (prob_floor == '0) ? 16'd1 : prob_floor;
    assign batch_eff = (batch_size == '0) ? 13'd1 : batch_size;
    assign p_eff = (prob > {1'b0, floor_eff}) ? prob : {1'b0, floor_eff};

    always_comb
    begin
        msb = '0;
        for (int i = 0; i < P_W; i++)
        begin
            if (p_reg[i])
            begin
                msb = 5'(i);
            end
        end
    end
    assign norm = p_reg << (5'd16 - msb);

    assign interp_prod = diff_reg * rem_reg;
    assign lm = {1'b0, lo_reg} + {1'b0, intp_reg};
    assign ln2_part = 20'(nexp_reg) * 20'(LN2_Q16);
    assign ln_mag = ln_reg[LN_W-1] ? 20'(-ln_reg) : 20'(ln_reg);
    assign term_prod = label_reg * ln_mag;
    assign tmag = term_prod[36:16];
    assign acc_wide = SUM_W'(sum_reg) + (SUM_W + 1)'(term_reg);
    assign sum_mag = sum_reg[SUM_W-1] ? SUM_W'(-sum_reg) : SUM_W'(sum_reg);
    assign gmag = upstream_grad[31] ? 32'(-upstream_grad) : 32'(upstream_grad);
    assign rmd_sh = {rmd_reg[RMD_W-2:0], dvd_reg[DVD_W-1]};
    assign qbit = (rmd_sh >= {1'b0, dsr_reg});

    assign neg_out = (act_reg == ACT_BACKWARD) ? !neg_reg : neg_reg;
    always_comb
    begin
        if (neg_out)
        begin
            result = (dvd_reg >= DVD_W'(33'h080000000)) ? 32'sh80000000
                                                        : 32'(-dvd_reg[31:0]);
        end
        else
        begin
            result = (dvd_reg > DVD_W'(32'h7FFFFFFF)) ? 32'sh7FFFFFFF
                                                      : 32'(dvd_reg[31:0]);
        end
    end

    always_comb
    begin
        sum_next = sum_reg;
        if (cmd.acc)
        begin
            if (acc_wide > (SUM_W + 1)'(signed'({2'b00, {(SUM_W-1){1'b1}}})))
            begin
                sum_next = {1'b0, {(SUM_W-1){1'b1}}};
            end
            else if (acc_wide < (SUM_W + 1)'(signed'({2'b11, {(SUM_W-1){1'b0}}})))
            begin
                sum_next = {1'b1, {(SUM_W-1){1'b0}}};
            end
            else
            begin
                sum_next = acc_wide[SUM_W-1:0];
            end
        end
        else if (cmd.load_fwd)
        begin
            sum_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_reg <= '0;
        end
        else
        begin
            sum_reg <= sum_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            act_reg <= action;
            last_reg <= last;
            p_reg <= p_eff;
            label_reg <= label;
        end
        if (cmd.log_norm)
        begin
            nexp_reg <= 5'd16 - msb;
            idx_reg <= norm[15 -: IDX_W];
            rem_reg <= {norm[15-IDX_W:0], {IDX_W{1'b0}}};
        end
        if (cmd.tab_read)
        begin
            lo_reg <= LN_TAB[idx_reg];
            diff_reg <= LN_TAB[(IDX_W + 1)'(idx_reg) + 1'b1] - LN_TAB[idx_reg];
        end
        if (cmd.interp)
        begin
            intp_reg <= interp_prod[31:16];
        end
        if (cmd.ln_sum)
        begin
            ln_reg <= signed'(LN_W'(lm)) - signed'(LN_W'(ln2_part));
        end
        if (cmd.term)
        begin
            term_reg <= (ln_reg <= 0) ? signed'(TERM_W'(tmag)) : -signed'(TERM_W'(tmag));
        end
        if (cmd.load_fwd)
        begin
            dvd_reg <= DVD_W'(sum_mag);
            dsr_reg <= DSR_W'(batch_eff);
            rmd_reg <= '0;
            neg_reg <= sum_reg[SUM_W-1];
        end
        if (cmd.load_bwd)
        begin
            dvd_reg <= gmag * label_reg;
            dsr_reg <= batch_eff * p_reg;
            rmd_reg <= '0;
            neg_reg <= upstream_grad[31];
        end
        if (cmd.div_step)
        begin
            rmd_reg <= qbit ? rmd_sh - {1'b0, dsr_reg} : rmd_sh;
            dvd_reg <= {dvd_reg[DVD_W-2:0], qbit};
        end
        if (cmd.finish)
        begin
            kind_reg <= act_reg;
            value_reg <= result;
        end
    end

    assign sts.act = act_reg;
    assign sts.last = last_reg;
    assign kind = kind_reg;
    assign value = value_reg;

endmodule

/* src/cross_entropy_loss_unit.sv */
// Top level of the cross-entropy loss unit with its configuration registers.
//
//   Channel  Direction  Handshake            Payload
//   request  in         in_valid / in_stall  action, prob, label, last
//   result   out        out_valid / out_stall kind, value
//   config   in         APB psel / penable   paddr, pwdata, prdata
//
// A forward request that is not last runs the log, table, interpolation, sum, term and
// accumulate steps; a last one then also loads the divider. A backward request loads it right after capture.
// The one-bit-per-cycle divider, 49 steps, is the long part of both.
// Reset clears the loss sum, the controller and the registers to their defaults.
// A waiting result holds while out_stall is high; the next request is still taken.
module cross_entropy_loss_unit (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_stall,
    input  logic                        action,
    input  logic [16:0]                 prob,
    input  logic [16:0]                 label,
    input  logic                        last,
    output logic                        out_valid,
    input  logic                        out_stall,
    output logic                        kind,
    output logic signed [31:0]          value,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [cel_pkg::ADDR_W-1:0]  paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready
);
    import cel_pkg::*;

    logic [15:0] floor_reg;
    logic [12:0] batch_reg;
    logic signed [31:0] grad_reg;
    logic wr_en;
    cmd_t cmd;
    status_t sts;

    assign pready = 1'b1;
    assign wr_en = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            floor_reg <= 16'd1;
            batch_reg <= 13'd1;
            grad_reg <= 32'sd65536;
        end
        else if (wr_en)
        begin
            case (paddr)
                ADDR_FLOOR: floor_reg <= pwdata[15:0];
                ADDR_BATCH: batch_reg <= pwdata[12:0];
                ADDR_GRAD: grad_reg <= pwdata;
                default: ;
            endcase
        end
    end

    always_comb
    begin
        case (paddr)
            ADDR_FLOOR: prdata = {16'd0, floor_reg};
            ADDR_BATCH: prdata = {19'd0, batch_reg};
            ADDR_GRAD: prdata = grad_reg;
            default: prdata = '0;
        endcase
    end

    cel_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .sts       (sts),
        .cmd       (cmd)
    );

    cel_datapath u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .sts           (sts),
        .action        (action),
        .prob          (prob),
        .label         (label),
        .last          (last),
        .prob_floor    (floor_reg),
        .batch_size    (batch_reg),
        .upstream_grad (grad_reg),
        .kind          (kind),
        .value         (value)
    );

endmodule

/* tb/sv/cross_entropy_loss_unit_tb.sv */
// Testbench of the cross-entropy loss unit: directed and random requests checked against a built-in predictor.
`timescale 1ns / 1ps

module cross_entropy_loss_unit_tb;
    import cel_pkg::*;

    localparam int CYCLE_LIMIT = 1500000;
    localparam longint SUM_HI = 64'sd140737488355327;
    localparam longint SUM_LO = -64'sd140737488355328;

    typedef struct packed {
        logic        action;
        logic [16:0] prob;
        logic [16:0] label;
        logic        last;
    } request_t;

    typedef struct packed {
        logic        kind;
        logic [31:0] value;
    } loss_out_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_stall;
    logic action = 1'b0;
    logic [16:0] prob = '0;
    logic [16:0] label = '0;
    logic last = 1'b0;
    logic out_valid;
    logic out_stall = 1'b0;
    logic kind;
    logic signed [31:0] value;
    logic psel = 1'b0;
    logic penable = 1'b0;
    logic pwrite = 1'b0;
    logic [ADDR_W-1:0] paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic pready;

    request_t  request_q[$];
    loss_out_t loss_exp_q[$];
    logic [31:0] ln_lut [0:LOG_TABLE_DEPTH];
    logic [15:0] floor_reg = 16'd1;
    logic [12:0] batch_reg = 13'd1;
    logic [31:0] grad_reg = 32'd65536;
    longint loss_acc = 0;
    int errors = 0;
    int cycles = 0;
    int gap_cnt = 0;
    int stall_run = 0;
    int hold_cnt = 0;
    int hold_reqs = 0;
    int hold_done = 0;
    logic quiet = 1'b0;

    cross_entropy_loss_unit DUT (.*);

    initial
    begin
        forever #2 clk = ~clk;
    end

    function automatic void fill_ln_lut();
        longint unsigned z, z2, pw, acc, n;
        for (int k = 0; k <= LOG_TABLE_DEPTH; k++)
        begin
            z = (longint'(k) << 32) / (2 * LOG_TABLE_DEPTH + k);
            z2 = (z * z) >> 32;
            pw = z;
            acc = 0;
            for (n = 0; pw != 0 && n < 64; n++)
            begin
                acc += pw / (2 * n + 1);
                pw = (pw * z2) >> 32;
            end
            ln_lut[k] = 32'((2 * acc + 32768) >> 16);
        end
    endfunction

    function automatic longint ln_fixed(logic [16:0] p);
        int e;
        longint unsigned f16, pos, idx, rem, lo, hi;
        e = 16;
        while (e > 0 && p[e] == 1'b0)
            e--;
        f16 = (longint'(p) << (16 - e)) & 64'hFFFF;
        pos = f16 * LOG_TABLE_DEPTH;
        idx = pos >> 16;
        rem = pos & 64'hFFFF;
        lo = ln_lut[idx];
        hi = ln_lut[idx + 1];
        return longint'(e - 16) * LN2_Q16 + longint'(lo + (((hi - lo) * rem) >> 16));
    endfunction

    task automatic predict_loss(request_t r);
        longint unsigned p, bsz, gmag, q, den;
        longint l, term, v;
        p = (r.prob > ((floor_reg == 0) ? 1 : floor_reg)) ? r.prob
            : ((floor_reg == 0) ? 1 : floor_reg);
        bsz = (batch_reg == 0) ? 1 : batch_reg;
        if (r.action == ACT_FORWARD)
        begin
            l = ln_fixed(17'(p));
            if (l <= 0)
                term = longint'((longint'(r.label) * (-l)) >>> 16);
            else
                term = -longint'((longint'(r.label) * l) >>> 16);
            loss_acc += term;
            if (loss_acc > SUM_HI)
                loss_acc = SUM_HI;
            if (loss_acc < SUM_LO)
                loss_acc = SUM_LO;
            if (r.last)
            begin
                v = loss_acc / longint'(bsz);
                if (v > 64'sd2147483647)
                    v = 64'sd2147483647;
                if (v < -64'sd2147483648)
                    v = -64'sd2147483648;
                loss_acc = 0;
                loss_exp_q.push_back('{1'b0, 32'(v)});
            end
        end
        else
        begin
            gmag = grad_reg[31] ? longint'(32'(~grad_reg + 1)) : longint'(grad_reg);
            if (grad_reg == 32'h80000000)
                gmag = 64'h80000000;
            den = bsz * p;
            q = (gmag * r.label) / den;
            if (q > 64'h80000000)
                q = 64'h80000000;
            if (grad_reg[31])
                v = (q > 64'h7FFFFFFF) ? 64'sd2147483647 : longint'(q);
            else
                v = -longint'(q);
            loss_exp_q.push_back('{1'b1, 32'(v)});
        end
    endtask

    function automatic int gap_len();
        int r;
        r = $urandom_range(99);
        if (r < 60)
            return 0;
        if (r < 95)
            return $urandom_range(3, 1);
        return $urandom_range(80, 20);
    endfunction

    function automatic logic [16:0] rand_prob();
        case ($urandom_range(5))
            0: return 17'($urandom);
            1: return 17'($urandom_range(255));
            2: return 17'($urandom_range(65536, 60000));
            3: return 17'($urandom_range(131071, 65537));
            default: return 17'($urandom_range(65536));
        endcase
    endfunction

    function automatic request_t rand_request();
        request_t r;
        r.action = $urandom_range(1);
        r.prob = rand_prob();
        r.label = ($urandom_range(3) == 0) ? 17'($urandom) : 17'($urandom_range(65536));
        r.last = ($urandom_range(5) == 0);
        return r;
    endfunction

    // Request driver.
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (!(in_valid && in_stall))
        begin
            if (gap_cnt > 0)
            begin
                in_valid <= 1'b0;
                gap_cnt <= gap_cnt - 1;
            end
            else if (request_q.size() > 0)
            begin
                {action, prob, label, last} <= request_q.pop_front();
                in_valid <= 1'b1;
                gap_cnt <= quiet ? 0 : gap_len();
            end
            else
                in_valid <= 1'b0;
        end
    end

    // Result stall generator.
    always @(posedge clk)
    begin
        if (hold_reqs != hold_done)
        begin
            hold_done <= hold_done + 1;
            hold_cnt <= 600;
            out_stall <= 1'b1;
        end
        else if (hold_cnt > 0)
        begin
            hold_cnt <= hold_cnt - 1;
            out_stall <= 1'b1;
        end
        else if (quiet)
            out_stall <= 1'b0;
        else if (stall_run > 0)
            stall_run <= stall_run - 1;
        else if ($urandom_range(3) != 0)
        begin
            out_stall <= 1'b0;
            stall_run <= $urandom_range(8);
        end
        else
        begin
            out_stall <= 1'b1;
            stall_run <= ($urandom_range(9) == 0) ? $urandom_range(80, 30)
                : $urandom_range(2);
        end
    end

    // Prediction on accepted requests and checking of accepted results.
    always @(posedge clk)
    begin
        loss_out_t exp_out;
        if (rst_n && in_valid && !in_stall)
            predict_loss('{action, prob, label, last});
        if (rst_n && out_valid && !out_stall)
        begin
            if (loss_exp_q.size() == 0)
            begin
                $error("unexpected result: kind %0d value %0d", kind, value);
                errors++;
            end
            else
            begin
                exp_out = loss_exp_q.pop_front();
                if (kind !== exp_out.kind)
                begin
                    $error("kind: expected %0d, got %0d", exp_out.kind, kind);
                    errors++;
                end
                if (value !== exp_out.value)
                begin
                    $error("value: expected %0d, got %0d",
                           $signed(exp_out.value), value);
                    errors++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("tb: failure");
            $finish;
        end
    end

    task automatic reg_write(logic [ADDR_W-1:0] addr, logic [31:0] data);
        @(posedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= addr;
        pwdata <= data;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        case (addr)
            ADDR_FLOOR: floor_reg = data[15:0];
            ADDR_BATCH: batch_reg = data[12:0];
            default: grad_reg = data;
        endcase
    endtask

    task automatic drain();
        while (request_q.size() > 0 || in_valid || loss_exp_q.size() > 0)
            @(posedge clk);
        repeat (80) @(posedge clk);
    endtask

    task automatic configure(logic [15:0] fl, logic [12:0] bs, logic [31:0] gr);
        reg_write(ADDR_FLOOR, {16'd0, fl});
        reg_write(ADDR_BATCH, {19'd0, bs});
        reg_write(ADDR_GRAD, gr);
    endtask

    initial
    begin
        logic [16:0] edges [5];
        edges = '{17'd0, 17'd1, 17'd65535, 17'd65536, 17'd131071};
        fill_ln_lut();
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (edges[i])
        begin
            request_q.push_back('{ACT_FORWARD, edges[i], edges[4 - i], 1'b0});
            request_q.push_back('{ACT_BACKWARD, edges[i], edges[i], 1'b1});
        end
        request_q.push_back('{ACT_FORWARD, 17'd1, 17'd131071, 1'b1});
        request_q.push_back('{ACT_FORWARD, 17'd131071, 17'd131071, 1'b1});
        request_q.push_back('{ACT_FORWARD, 17'd32768, 17'd65536, 1'b1});
        drain();

        for (int ph = 0; ph < 8; ph++)
        begin
            case (ph)
                0: configure(16'd0, 13'd0, 32'h80000000);
                1: configure(16'hFFFF, 13'h1FFF, 32'h7FFFFFFF);
                2: configure(16'd1, 13'd4096, 32'hFFFF0000);
                3: configure(16'd655, 13'd1, 32'd65536);
                4: configure(16'd1, 13'd1, 32'h80000000);
                default: configure(16'($urandom_range(2000)), 13'($urandom_range(16)),
                                   $urandom);
            endcase
            quiet = (ph == 3);
            if (ph == 0)
            begin
                request_q.push_back('{ACT_BACKWARD, 17'd1, 17'd131071, 1'b0});
                request_q.push_back('{ACT_BACKWARD, 17'd0, 17'd0, 1'b0});
            end
            if (ph == 2)
                hold_reqs = hold_reqs + 1;
            repeat (105)
                request_q.push_back(rand_request());
            drain();
        end

        if (errors == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

/* cross_entropy_loss_unit.f */
src/cel_pkg.sv
src/cel_ctrl.sv
src/cel_datapath.sv
src/cross_entropy_loss_unit.sv
tb/sv/cross_entropy_loss_unit_tb.sv
